// File: design/cbbl_pkg.sv
package cbbl_pkg;

    localparam int MAX_LINE   = 1024;
    localparam int MAX_RADIUS = 50;

    localparam int PIX_W = 32;
    localparam int CH_W  = 8;
    localparam int CH_N  = 4;
    localparam int RAD_W = 6;
    localparam int LEN_W = 11;
    localparam int DIV_W = RAD_W + 1;

    localparam int CELLS  = 2 * MAX_RADIUS + 1;
    localparam int POS_W  = $clog2(MAX_LINE + (1 << RAD_W));
    localparam int SUM_W  = $clog2(CELLS * 255 + 1);
    localparam int RCP_SH = SUM_W + $clog2(CELLS);
    localparam int RCP_W  = RCP_SH + 1;

    localparam int FIFO_D  = 4;
    localparam int FIFO_AW = $clog2(FIFO_D);

    localparam int LEN_RST = (1024 > MAX_LINE) ? MAX_LINE : 1024;

    localparam logic REG_RADIUS = 1'b0;
    localparam logic REG_LENGTH = 1'b1;

    typedef enum logic {
        ST_RUN,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctl_t;

    typedef struct packed {
        logic push;
        logic load;
        logic emit;
        logic last;
    } push_ctl_t;

    typedef struct packed {
        logic             valid;
        logic             last;
        logic [PIX_W-1:0] pixel;
    } mean_res_t;

endpackage

// File: design/cbbl_cell.sv
module cbbl_cell (
    input  logic                       clk,
    input  cbbl_pkg::cell_ctl_t        ctl,
    input  logic                       is_entry,
    input  logic [cbbl_pkg::PIX_W-1:0] src,
    input  logic [cbbl_pkg::PIX_W-1:0] nb,
    output logic [cbbl_pkg::PIX_W-1:0] q
);
    import cbbl_pkg::*;

    logic [PIX_W-1:0] q_reg;
    logic [PIX_W-1:0] q_next;

    always_comb
    begin
        q_next = q_reg;
        if (ctl.load)
        begin
            q_next = src;
        end
        else if (ctl.shift)
        begin
            q_next = is_entry ? src : nb;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

// File: design/cbbl_mean.sv
module cbbl_mean (
    input  logic                       clk,
    input  logic                       rst_n,
    input  cbbl_pkg::push_ctl_t        ctl,
    input  logic [cbbl_pkg::PIX_W-1:0] pixel,
    input  logic [cbbl_pkg::PIX_W-1:0] oldest,
    input  logic [cbbl_pkg::RAD_W-1:0] radius,
    output cbbl_pkg::mean_res_t        res,
    output logic [1:0]                 inflight
);
    import cbbl_pkg::*;

    localparam int PROD_W = SUM_W + RCP_W;

    logic [RCP_W-1:0] rcp_tab [0:MAX_RADIUS];

    for (genvar g = 0; g <= MAX_RADIUS; g++)
    begin : g_rcp
        // ceil(2^RCP_SH / (2g+1)), exact for every window sum
        localparam longint unsigned RCP =
            ((64'd1 << RCP_SH) + 64'(2 * g)) / 64'(2 * g + 1);
        assign rcp_tab[g] = RCP_W'(RCP);
    end

    logic [DIV_W-1:0]  div;
    logic [RCP_W-1:0]  rcp_reg;
    logic [SUM_W-1:0]  sum_reg  [CH_N];
    logic [SUM_W-1:0]  sum_next [CH_N];
    logic [PROD_W-1:0] prod     [CH_N];
    logic [PIX_W-1:0]  q_reg;
    logic [PIX_W-1:0]  q_next;
    logic              v1_reg, v1_next;
    logic              l1_reg, l1_next;
    logic              v2_reg, v2_next;
    logic              l2_reg, l2_next;

    assign div = {radius, 1'b1};

    always_comb
    begin
        for (int c = 0; c < CH_N; c++)
        begin
            sum_next[c] = sum_reg[c];
            if (ctl.load)
            begin
                sum_next[c] = SUM_W'(SUM_W'(pixel[c*CH_W +: CH_W]) * SUM_W'(div));
            end
            else if (ctl.push)
            begin
                sum_next[c] = sum_reg[c] + SUM_W'(pixel[c*CH_W +: CH_W])
                              - SUM_W'(oldest[c*CH_W +: CH_W]);
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < CH_N; c++)
        begin
            prod[c] = PROD_W'(sum_reg[c]) * PROD_W'(rcp_reg);
            q_next[c*CH_W +: CH_W] = prod[c][RCP_SH +: CH_W];
        end
    end

    always_comb
    begin
        v1_next = ctl.push && ctl.emit;
        l1_next = ctl.last;
        v2_next = v1_reg;
        l2_next = l1_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < CH_N; c++)
        begin
            sum_reg[c] <= sum_next[c];
        end
        rcp_reg <= rcp_tab[radius];
        q_reg   <= q_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            l1_reg <= 1'b0;
            v2_reg <= 1'b0;
            l2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            l1_reg <= l1_next;
            v2_reg <= v2_next;
            l2_reg <= l2_next;
        end
    end

    assign res.valid = v2_reg;
    assign res.last  = l2_reg;
    assign res.pixel = q_reg;
    assign inflight  = {1'b0, v1_reg} + {1'b0, v2_reg};

endmodule

// File: design/clamped_box_blur_line.sv
// Channel  Dir  Signals                                 Carries
// s_       in   s_tvalid s_tready s_tdata               pixel_in
// m_       out  m_tvalid m_tready m_tdata m_tlast       pixel_out, line_end
// apb      in   psel penable pwrite paddr pwdata prdata blur_radius @0, line_length @4
//
// One pixel per cycle while a line streams in; after the last pixel of a line
// the window chain is flushed with blur_radius pushes of it, input held off,
// since the running sum takes one update per cycle. Results pass the mean's
// sum and output registers to the output FIFO. Reset clears control; the
// chain needs no clearing, the first pixel of each line loads every cell. The
// 4-entry output FIFO absorbs stalls; input stops only when it could overflow.
module clamped_box_blur_line (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // pixel_in[31:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // pixel_out[31:0]
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import cbbl_pkg::*;

    logic [RAD_W-1:0] radius_reg, radius_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [RAD_W-1:0] wv_rad;
    logic [LEN_W-1:0] wv_len;
    logic             cfg_wr;

    state_t           state_reg, state_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [RAD_W-1:0] rem_reg, rem_next;
    logic [PIX_W-1:0] last_px_reg;

    logic             room;
    logic             accept;
    logic             flush_push;
    logic             push;
    logic             last_px;
    logic             final_push;
    logic [PIX_W-1:0] push_px;
    push_ctl_t        pctl;
    cell_ctl_t        cctl;
    logic [PIX_W-1:0] cell_q [CELLS];
    mean_res_t        res;
    logic [1:0]       inflight;

    logic [PIX_W-1:0]   fifo_pix_reg  [FIFO_D];
    logic               fifo_last_reg [FIFO_D];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]   cnt_reg, cnt_next;
    logic [FIFO_AW+1:0] occ;
    logic               pop;

    // configuration
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign wv_rad = pwdata[RAD_W-1:0];
    assign wv_len = pwdata[LEN_W-1:0];

    always_comb
    begin
        radius_next = radius_reg;
        len_next    = len_reg;
        if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_RADIUS:
                begin
                    radius_next = (32'(wv_rad) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : wv_rad;
                end
                REG_LENGTH:
                begin
                    if (wv_len == '0)
                    begin
                        len_next = LEN_W'(1);
                    end
                    else if (32'(wv_len) > MAX_LINE)
                    begin
                        len_next = LEN_W'(MAX_LINE);
                    end
                    else
                    begin
                        len_next = wv_len;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_RADIUS: prdata = 32'(radius_reg);
            REG_LENGTH: prdata = 32'(len_reg);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= '0;
            len_reg    <= LEN_W'(LEN_RST);
        end
        else
        begin
            radius_reg <= radius_next;
            len_reg    <= len_next;
        end
    end

    // line sequencing
    assign occ     = (FIFO_AW+2)'(cnt_reg) + (FIFO_AW+2)'(inflight);
    assign room    = occ < (FIFO_AW+2)'(FIFO_D);
    assign last_px = pos_reg == POS_W'(len_reg) - POS_W'(1);

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        rem_next   = rem_reg;
        s_tready   = 1'b0;
        flush_push = 1'b0;

        unique case (state_reg)
            ST_RUN:   s_tready   = room;
            ST_FLUSH: flush_push = room;
            default:
            begin
            end
        endcase

        accept     = s_tvalid && s_tready;
        push       = accept || flush_push;
        final_push = (accept && last_px && radius_reg == '0)
                     || (flush_push && rem_reg == RAD_W'(1));

        if (cfg_wr)
        begin
            state_next = ST_RUN;
            pos_next   = '0;
        end
        else if (push)
        begin
            if (final_push)
            begin
                state_next = ST_RUN;
                pos_next   = '0;
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
                if (accept && last_px)
                begin
                    state_next = ST_FLUSH;
                    rem_next   = radius_reg;
                end
                else if (flush_push)
                begin
                    rem_next = rem_reg - RAD_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
            pos_reg   <= '0;
            rem_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            rem_reg   <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            last_px_reg <= s_tdata;
        end
    end

    // window chain: entry at cell 2R, oldest pixel leaves from cell 0
    assign push_px    = (state_reg == ST_FLUSH) ? last_px_reg : s_tdata;
    assign pctl.push  = push;
    assign pctl.load  = accept && (pos_reg == '0);
    assign pctl.emit  = pos_reg >= POS_W'(radius_reg);
    assign pctl.last  = final_push;
    assign cctl.load  = pctl.load;
    assign cctl.shift = push && !pctl.load;

    for (genvar k = 0; k < CELLS; k++)
    begin : g_cell
        logic             is_entry;
        logic [PIX_W-1:0] nb;

        assign is_entry = int'({radius_reg, 1'b0}) == k;

        if (k == CELLS - 1)
        begin : g_top
            assign nb = push_px;
        end
        else
        begin : g_mid
            assign nb = cell_q[k+1];
        end

        cbbl_cell u_cell (
            .clk      (clk),
            .ctl      (cctl),
            .is_entry (is_entry),
            .src      (push_px),
            .nb       (nb),
            .q        (cell_q[k])
        );
    end

    cbbl_mean u_mean (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (pctl),
        .pixel    (push_px),
        .oldest   (cell_q[0]),
        .radius   (radius_reg),
        .res      (res),
        .inflight (inflight)
    );

    // output FIFO
    assign m_tvalid = cnt_reg != '0;
    assign m_tdata  = fifo_pix_reg[rd_ptr_reg];
    assign m_tlast  = fifo_last_reg[rd_ptr_reg];
    assign pop      = m_tvalid && m_tready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_AW'(res.valid);
        rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
        cnt_next    = cnt_reg + (FIFO_AW+1)'(res.valid) - (FIFO_AW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            fifo_pix_reg[wr_ptr_reg]  <= res.pixel;
            fifo_last_reg[wr_ptr_reg] <= res.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule
